// File: hw/rtl/sci_pkg.sv
// Shared types and constants for the sound chip interrupt controller.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package sci_pkg;

    // Width of the source masks carried on the ports.
    localparam int DATA_W        = 11;
    // Default number of interrupt sources and the largest supported count.
    localparam int NUM_SOURCES_DEF = 11;
    localparam int SRC_MAX_W     = 16;
    // Software request source, written through a pending write.
    localparam int SOFT_REQ_BIT  = 5;
    // Sources above this slot share its level-select bits.
    localparam int TOP_SLOT      = 7;
    localparam int SLOT_COUNT    = 8;
    localparam int LEVEL_W       = 3;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 8;

    typedef enum logic [2:0] {
        OP_LOCAL_ENABLE  = 3'd0,
        OP_LOCAL_PENDING = 3'd1,
        OP_LOCAL_CLEAR   = 3'd2,
        OP_HOST_ENABLE   = 3'd3,
        OP_HOST_PENDING  = 3'd4,
        OP_HOST_CLEAR    = 3'd5,
        OP_RAISE         = 3'd6
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEVEL_SEL0 = 2'd0,
        CFG_LEVEL_SEL1 = 2'd1,
        CFG_LEVEL_SEL2 = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] sel2;
        logic [SLOT_COUNT-1:0] sel1;
        logic [SLOT_COUNT-1:0] sel0;
    } level_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/sci_mask_update.sv
// Enable and pending mask registers for the local and host sides.
// Applies one request per accepted cycle; depends on sci_pkg.
`default_nettype none

module sci_mask_update
    import sci_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   fire,
    input  wire cmd_t                   cmd,
    output logic      [NUM_SOURCES-1:0] local_active_next,
    output logic      [NUM_SOURCES-1:0] host_active_next
);

    logic [NUM_SOURCES-1:0] local_enable_reg, local_enable_next;
    logic [NUM_SOURCES-1:0] local_pending_reg, local_pending_next;
    logic [NUM_SOURCES-1:0] host_enable_reg, host_enable_next;
    logic [NUM_SOURCES-1:0] host_pending_reg, host_pending_next;
    logic [SRC_MAX_W-1:0]   data_ext;
    logic [NUM_SOURCES-1:0] d;
    logic [NUM_SOURCES-1:0] soft_req;

    assign data_ext = {{(SRC_MAX_W-DATA_W){1'b0}}, cmd.data};
    assign d        = data_ext[NUM_SOURCES-1:0];

    // A pending write can only set the software request bit.
    always_comb
    begin
        soft_req               = '0;
        soft_req[SOFT_REQ_BIT] = d[SOFT_REQ_BIT];
    end

    always_comb
    begin
        local_enable_next  = local_enable_reg;
        local_pending_next = local_pending_reg;
        host_enable_next   = host_enable_reg;
        host_pending_next  = host_pending_reg;
        if (fire)
        begin
            case (op_t'(cmd.op))
                OP_LOCAL_ENABLE:  local_enable_next  = d;
                OP_LOCAL_PENDING: local_pending_next = local_pending_reg | soft_req;
                OP_LOCAL_CLEAR:   local_pending_next = local_pending_reg & ~d;
                OP_HOST_ENABLE:   host_enable_next   = d;
                OP_HOST_PENDING:  host_pending_next  = host_pending_reg | soft_req;
                OP_HOST_CLEAR:    host_pending_next  = host_pending_reg & ~d;
                OP_RAISE:
                begin
                    local_pending_next = local_pending_reg | d;
                    host_pending_next  = host_pending_reg | d;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_enable_reg  <= '0;
            local_pending_reg <= '0;
            host_enable_reg   <= '0;
            host_pending_reg  <= '0;
        end
        else
        begin
            local_enable_reg  <= local_enable_next;
            local_pending_reg <= local_pending_next;
            host_enable_reg   <= host_enable_next;
            host_pending_reg  <= host_pending_next;
        end
    end

    assign local_active_next = local_enable_next & local_pending_next;
    assign host_active_next  = host_enable_next & host_pending_next;

endmodule

`default_nettype wire

// File: hw/rtl/sci_level_enc.sv
// Priority encoder that finds the lowest active local source and looks up
// its three-bit level in the level-select registers. Depends on sci_pkg.
`default_nettype none

module sci_level_enc
    import sci_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic       [NUM_SOURCES-1:0] active,
    input  wire level_cfg_t                   level_cfg,
    output logic            [LEVEL_W-1:0]     level
);

    always_comb
    begin
        logic [2:0] slot;
        level = '0;
        slot  = '0;
        // Walk from the top down so the lowest active source wins.
        for (int i = NUM_SOURCES - 1; i >= 0; i--)
        begin
            slot = (i > TOP_SLOT) ? 3'(TOP_SLOT) : 3'(i);
            if (active[i])
            begin
                level = {level_cfg.sel2[slot], level_cfg.sel1[slot],
                         level_cfg.sel0[slot]};
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sound_chip_interrupt_controller.sv
// Top level of the sound chip interrupt controller: handshakes, level-select
// registers and the result register. Depends on sci_pkg, sci_mask_update and
// sci_level_enc.
//
// Each accepted request updates the local and host enable/pending masks and
// produces one result in the next cycle: both active masks, the host IRQ line
// and the level of the lowest active local source. The block takes one
// request per cycle while not stalled; the single result register is refilled
// in the same cycle its content is taken, so in_ready is low only while a
// result waits and out_ready is low. Level-select writes are always accepted
// and should be made while no request is in flight.
`default_nettype none

module sound_chip_interrupt_controller
    import sci_pkg::*;
#(
    parameter int NUM_SOURCES = NUM_SOURCES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [2:0]             operation,
    input  wire logic [DATA_W-1:0]      data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [DATA_W-1:0]      local_active,
    output logic      [LEVEL_W-1:0]     local_level,
    output logic      [DATA_W-1:0]      host_active,
    output logic                        host_irq,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    level_cfg_t             level_cfg_reg;
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      local_active_reg;
    logic [LEVEL_W-1:0]     local_level_reg;
    logic [DATA_W-1:0]      host_active_reg;
    logic                   host_irq_reg;
    logic                   fire;
    cmd_t                   cmd;
    logic [NUM_SOURCES-1:0] la_next;
    logic [NUM_SOURCES-1:0] ha_next;
    logic [SRC_MAX_W-1:0]   la_ext;
    logic [SRC_MAX_W-1:0]   ha_ext;
    logic [LEVEL_W-1:0]     level_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign cmd.op   = operation;
    assign cmd.data = data;

    sci_mask_update #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_mask_update (
        .clk               (clk),
        .rst_n             (rst_n),
        .fire              (fire),
        .cmd               (cmd),
        .local_active_next (la_next),
        .host_active_next  (ha_next)
    );

    sci_level_enc #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_level_enc (
        .active    (la_next),
        .level_cfg (level_cfg_reg),
        .level     (level_next)
    );

    assign la_ext = SRC_MAX_W'(la_next);
    assign ha_ext = SRC_MAX_W'(ha_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEVEL_SEL0: level_cfg_reg.sel0 <= cfg_data;
                CFG_LEVEL_SEL1: level_cfg_reg.sel1 <= cfg_data;
                CFG_LEVEL_SEL2: level_cfg_reg.sel2 <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            local_active_reg <= la_ext[DATA_W-1:0];
            local_level_reg  <= level_next;
            host_active_reg  <= ha_ext[DATA_W-1:0];
            host_irq_reg     <= |ha_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign local_active = local_active_reg;
    assign local_level  = local_level_reg;
    assign host_active  = host_active_reg;
    assign host_irq     = host_irq_reg;

endmodule

`default_nettype wire
